@@ src/msort_pkg.sv @@
`timescale 1ns / 1ps

package msort_pkg;

   // Widest store address the design supports (a capacity of up to 4096 entries).
   localparam int MAX_AW = 12;

   typedef struct packed {
      logic signed [31:0] value;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               final_result;
      logic               overflowed;
   } rsp_type;

   // Sequencer states. The load, merge and emit phases are kept in this order.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PASS,
      ST_RUN,
      ST_RD_I,
      ST_RD_J,
      ST_MERGE,
      ST_REFILL,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_HOLD
   } state_type;

   // Store access request from the sequencer to the two banks.
   typedef struct packed {
      logic              wr_en;
      logic              wr_sel;
      logic [MAX_AW-1:0] wr_addr;
      logic [31:0]       wr_data;
      logic [MAX_AW-1:0] rd_addr;
      logic              rd_sel;
   } mem_req_type;

endpackage

@@ src/msort_ram.sv @@
`timescale 1ns / 1ps

module msort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/msort_ctrl.sv @@
`timescale 1ns / 1ps

module msort_ctrl #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msort_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msort_pkg::rsp_type   rsp_data,
   output msort_pkg::mem_req_type mem_req,
   input  logic [31:0]          rd_data
);
   import msort_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 2;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic src_ff, src_in;
   logic side_ff, side_in;
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW-1:0] mid_ff, mid_in;
   logic [PW-1:0] hi_ff, hi_in;
   logic [PW-1:0] i_ff, i_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] k_ff, k_in;
   logic signed [31:0] hd_i_ff, hd_i_in;
   logic signed [31:0] hd_j_ff, hd_j_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [PW-1:0] n_pw;
   logic [PW-1:0] mid_calc;
   logic [PW-1:0] hi_calc;
   logic [PW-1:0] rd_pos;
   logic take_i;

   assign n_pw      = PW'(count_ff);
   assign mid_calc  = (lo_ff + width_ff > n_pw) ? n_pw : lo_ff + width_ff;
   assign hi_calc   = (lo_ff + (width_ff << 1) > n_pw) ? n_pw : lo_ff + (width_ff << 1);
   // Left head wins ties, so equal values keep their run order.
   assign take_i    = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (hd_i_ff <= hd_j_ff));

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         src_ff       <= src_in;
      end
      side_ff  <= side_in;
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      hd_i_ff  <= hd_i_in;
      hd_j_ff  <= hd_j_in;
      rsp_ff   <= rsp_in;
   end

   // Next state, store accesses and result register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      side_in      = side_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hd_i_in      = hd_i_ff;
      hd_j_in      = hd_j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_pos       = k_ff;
      req_stall    = 1'b1;
      mem_req      = '0;
      mem_req.rd_sel = src_ff;

      unique case (state_ff)
         ST_LOAD: begin
            // The input is never stalled here, so a valid beat is taken.
            req_stall = 1'b0;
            if (req_valid) begin
               // A beat past capacity is dropped and flags the whole set.
               if (count_ff < CAP_COUNT) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_sel  = 1'b0;
                  mem_req.wr_addr = MAX_AW'(count_ff[AW-1:0]);
                  mem_req.wr_data = req_data.value;
                  count_in        = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.final_item) begin
                  width_in = PW'(1);
                  src_in   = 1'b0;
                  state_in = ST_PASS;
               end
            end
         end

         ST_PASS: begin
            if (width_ff < n_pw) begin
               lo_in    = '0;
               state_in = ST_RUN;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end

         ST_RUN: begin
            if (lo_ff >= n_pw) begin
               // Pass done: the destination bank becomes the source.
               src_in   = ~src_ff;
               width_in = width_ff << 1;
               state_in = ST_PASS;
            end else begin
               mid_in   = mid_calc;
               hi_in    = hi_calc;
               i_in     = lo_ff;
               j_in     = mid_calc;
               k_in     = lo_ff;
               rd_pos   = lo_ff;
               state_in = ST_RD_I;
            end
         end

         ST_RD_I: begin
            hd_i_in  = rd_data;
            rd_pos   = j_ff;
            state_in = ST_RD_J;
         end

         ST_RD_J: begin
            hd_j_in  = rd_data;
            state_in = ST_MERGE;
         end

         ST_MERGE: begin
            if (k_ff == hi_ff) begin
               lo_in    = lo_ff + (width_ff << 1);
               state_in = ST_RUN;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_sel  = ~src_ff;
               mem_req.wr_addr = MAX_AW'(k_ff[AW-1:0]);
               mem_req.wr_data = take_i ? hd_i_ff : hd_j_ff;
               k_in            = k_ff + 1'b1;
               side_in         = take_i;
               if (take_i) begin
                  i_in   = i_ff + 1'b1;
                  rd_pos = i_ff + 1'b1;
               end else begin
                  j_in   = j_ff + 1'b1;
                  rd_pos = j_ff + 1'b1;
               end
               state_in = ST_REFILL;
            end
         end

         ST_REFILL: begin
            // Reload the head that was just consumed.
            if (side_ff) begin
               hd_i_in = rd_data;
            end else begin
               hd_j_in = rd_data;
            end
            state_in = ST_MERGE;
         end

         ST_EMIT_RD: begin
            rd_pos   = k_ff;
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.sorted_value = rd_data;
            rsp_in.final_result = (k_ff + 1'b1 == n_pw);
            rsp_in.overflowed   = ovf_ff;
            k_in                = k_ff + 1'b1;
            state_in            = ST_EMIT_HOLD;
         end

         ST_EMIT_HOLD: begin
            // Keep reading the next position so it is ready once this beat goes.
            rd_pos = k_ff;
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.final_result) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_OUT;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase

      mem_req.rd_addr = MAX_AW'(rd_pos[AW-1:0]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The set never holds more than the store can.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("loaded count beyond capacity");

   // Merge writes land in the bank that is not being read.
   a_merge_dst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && mem_req.wr_en) |-> (mem_req.wr_sel != src_ff))
      else $error("merge write hits source bank");

   // While a run is unfinished, at least one side still has an element.
   a_run_supply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && k_ff != hi_ff) |-> (i_ff < mid_ff || j_ff < hi_ff))
      else $error("merge ran out of input");

   // No result is pending once loading of a new set has begun.
   a_idle_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !rsp_valid_ff)
      else $error("result pending during load");

   // The last result of a set returns the block to loading when taken.
   a_set_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_ff.final_result) |=>
      (state_ff == ST_LOAD && count_ff == '0))
      else $error("set did not close after last result");

endmodule

@@ src/merge_sorter.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Ports                           Beat contents
// req      in         req_valid, req_stall, req_data  value, final_item
// rsp      out        rsp_valid, rsp_stall, rsp_data  sorted_value, final_result, overflowed
//
// Loading accepts one input beat per cycle; the store bank write port sets that.
// After the final beat, ceil(log2 n) merge passes run over the n elements, each reading
// one bank through its single read port and writing the other.
// Results leave one at a time while rsp_stall is low; stalls hold the output.
// req_stall is high from the final beat until the last result has been taken.
// Reset is synchronous and needs no clearing pass; data read from unwritten store places is never used.
module merge_sorter #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  msort_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output msort_pkg::rsp_type rsp_data
);
   import msort_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   mem_req_type mem_req;
   logic [31:0] rd_data0;
   logic [31:0] rd_data1;
   logic [31:0] rd_data;

   // Sequencer for load, merge passes and emission.
   msort_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   // Two banks swap roles of source and destination on every pass.
   msort_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_bank0 (
      .clock  (clock),
      .wr_en  (mem_req.wr_en && !mem_req.wr_sel),
      .wr_addr(mem_req.wr_addr[AW-1:0]),
      .wr_data(mem_req.wr_data),
      .rd_addr(mem_req.rd_addr[AW-1:0]),
      .rd_data(rd_data0)
   );

   msort_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_bank1 (
      .clock  (clock),
      .wr_en  (mem_req.wr_en && mem_req.wr_sel),
      .wr_addr(mem_req.wr_addr[AW-1:0]),
      .wr_data(mem_req.wr_data),
      .rd_addr(mem_req.rd_addr[AW-1:0]),
      .rd_data(rd_data1)
   );

   // Source bank read data back to the sequencer.
   assign rd_data = mem_req.rd_sel ? rd_data1 : rd_data0;

endmodule
